FILE: src/afe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afe_pkg;

  // Field kinds selected by the field_kind register.
  typedef enum logic [1:0] {
    KIND_CONST_BZ  = 2'd0,
    KIND_LINEAR_BZ = 2'd1,
    KIND_BIUNIFORM = 2'd2,
    KIND_CONST_BR  = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [2:0] REG_FIELD_KIND  = 3'd0;
  localparam logic [2:0] REG_BASE_FIELD  = 3'd1;
  localparam logic [2:0] REG_HIGH_FIELD  = 3'd2;
  localparam logic [2:0] REG_GRADIENT    = 3'd3;
  localparam logic [2:0] REG_HALF_LENGTH = 3'd4;

  // The normalized position u is held with this many fraction bits.
  localparam int         UBITS = 30;
  localparam logic [30:0] U_ONE = 31'h4000_0000;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic        ov;
    logic [31:0] v;
  } sat_t;

  // Per-item record that travels down the whole pipeline.
  typedef struct packed {
    logic [30:0]        r;
    logic               z_neg;
    logic               blend;
    logic               res_neg;
    logic signed [31:0] bz;
    logic signed [31:0] br;
    logic signed [31:0] at;
    logic               sat;
    logic [62:0]        num_mag;
  } cr_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t s;
    if (x > S32_MAX) begin
      s.ov = 1'b1;
      s.v  = 32'h7FFF_FFFF;
    end else if (x < S32_MIN) begin
      s.ov = 1'b1;
      s.v  = 32'h8000_0000;
    end else begin
      s.ov = 1'b0;
      s.v  = x[31:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/afe_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; the low bits are shifted in MSB first.
module afe_div #(
  parameter int NB = 32,
  parameter int DW = 31,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NB-1:0] low_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NB-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic [NB-1:0] vld_q;
  logic [DW-1:0] rem_q [NB];
  logic [NB-1:0] sh_q  [NB];
  logic [DW-1:0] den_q [NB];
  logic [PW-1:0] pay_q [NB];

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NB-1:0] sh_in;
    logic [DW-1:0] den_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign sh_in  = low_i;
      assign den_in = den_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = vld_q[i-1];
      assign rem_in = rem_q[i-1];
      assign sh_in  = sh_q[i-1];
      assign den_in = den_q[i-1];
      assign pay_in = pay_q[i-1];
    end

    assign trial = {rem_in, sh_in[NB-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        sh_q[i]  <= {sh_in[NB-2:0], ge};
        den_q[i] <= den_in;
        pay_q[i] <= pay_in;
      end
    end
  end

  assign valid_o = vld_q[NB-1];
  assign quo_o   = sh_q[NB-1];
  assign pay_o   = pay_q[NB-1];

endmodule

`default_nettype wire

FILE: src/afe_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Quintic blend of the bi-uniform kind: powers of u, the blend weight p,
// the radial term t and the products with the radius.
module afe_blend (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [29:0]            quo_i,
  input  afe_pkg::cr_t           cr_i,
  input  logic signed [31:0]     base_i,
  input  logic signed [31:0]     high_i,
  output logic                   valid_o,
  output afe_pkg::cr_t           cr_o,
  output logic [61:0]            mr_o,
  output logic signed [63:0]     ar_o
);
  import afe_pkg::*;

  localparam logic signed [36:0] P_ONE = 37'sd1 <<< UBITS;

  logic [6:0] vld_q;
  cr_t        b1_cr_q, b2_cr_q, b3_cr_q, b4_cr_q, b5_cr_q, b6_cr_q, b7_cr_q;

  logic signed [30:0] b1_u_q, b2_u_q, b3_u_q, b3_u3_q;
  logic [59:0]        b1_uu_q;
  logic [29:0]        b2_u2_q;
  logic signed [61:0] b2_u2u_q, b3_u5r_q;
  logic [30:0]        b2_w_q;
  logic [61:0]        b3_ww_q;
  logic [30:0]        b4_p_q;
  logic signed [64:0] b4_dw_q, b5_dp_q;
  logic signed [32:0] b5_t_q;
  logic [30:0]        b6_mag_q;
  logic [61:0]        b7_mr_q;
  logic signed [63:0] b7_ar_q;

  logic signed [30:0] u_d, u3, u5;
  logic [29:0]        u2;
  logic [30:0]        w2;
  logic signed [32:0] d;
  logic signed [36:0] psum, ps;
  logic [30:0]        p_d;
  logic signed [33:0] x;
  logic signed [37:0] x15;
  logic signed [32:0] t_d;
  sat_t               bz_s;
  cr_t                b6_cr_d;

  assign u_d  = cr_i.z_neg ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});
  assign u2   = b1_uu_q[59:30];
  assign u3   = $signed(b2_u2u_q[60:30]);
  assign u5   = $signed(b3_u5r_q[60:30]);
  assign w2   = b3_ww_q[60:30];
  assign d    = 33'(high_i) - 33'(base_i);
  assign psum = 37'(u5) * 37'sd3 - 37'(b3_u3_q) * 37'sd10 + 37'(b3_u_q) * 37'sd15
              + (37'sd1 <<< 33);
  assign ps   = psum >>> 4;

  always_comb begin
    if (ps < 0) begin
      p_d = '0;
    end else if (ps > P_ONE) begin
      p_d = U_ONE;
    end else begin
      p_d = ps[30:0];
    end
  end

  assign x   = $signed(b4_dw_q[63:30]);
  assign x15 = (38'(x) <<< 4) - 38'(x);
  assign t_d = $signed(x15[37:5]);

  assign bz_s = sat32(64'(base_i) + 64'($signed(b5_dp_q[64:30])));

  always_comb begin
    b6_cr_d = b5_cr_q;
    if (b5_cr_q.blend) begin
      b6_cr_d.bz      = bz_s.v;
      b6_cr_d.sat     = b5_cr_q.sat | bz_s.ov;
      b6_cr_d.res_neg = !b5_t_q[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_cr_q  <= cr_i;
      b1_u_q   <= u_d;
      b1_uu_q  <= quo_i * quo_i;

      b2_cr_q  <= b1_cr_q;
      b2_u_q   <= b1_u_q;
      b2_u2_q  <= u2;
      b2_u2u_q <= $signed({1'b0, u2}) * b1_u_q;
      b2_w_q   <= U_ONE - {1'b0, u2};

      b3_cr_q  <= b2_cr_q;
      b3_u_q   <= b2_u_q;
      b3_u3_q  <= u3;
      b3_u5r_q <= u3 * $signed({1'b0, b2_u2_q});
      b3_ww_q  <= b2_w_q * b2_w_q;

      b4_cr_q  <= b3_cr_q;
      b4_p_q   <= p_d;
      b4_dw_q  <= d * $signed({1'b0, w2});

      b5_cr_q  <= b4_cr_q;
      b5_dp_q  <= d * $signed({1'b0, b4_p_q});
      b5_t_q   <= t_d;

      b6_cr_q  <= b6_cr_d;
      b6_mag_q <= 31'(b5_t_q[32] ? -b5_t_q : b5_t_q);

      b7_cr_q  <= b6_cr_q;
      b7_mr_q  <= b6_mag_q * b6_cr_q.r;
      b7_ar_q  <= b6_cr_q.bz * $signed({1'b0, b6_cr_q.r});
    end
  end

  assign valid_o = vld_q[6];
  assign cr_o    = b7_cr_q;
  assign mr_o    = b7_mr_q;
  assign ar_o    = b7_ar_q;

endmodule

`default_nettype wire

FILE: src/axisymmetric_mag_field_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Axisymmetric magnetic field evaluator. Each input beat carries an axial
// position z (signed) and a radius r (unsigned) in fixed point with FRAC_BITS
// fraction bits; each output beat returns Bz, Br and the azimuthal vector
// potential A_theta for the field kind in the field_kind register (constant
// Bz, linear Bz, bi-uniform with a quintic blend over [-z0, z0], or constant
// Br). Every result saturates to 32 bits and then reports status 1; a
// constant-Br query at zero radius returns Bz of zero with status 2. The block
// is fully pipelined through two bit-per-stage dividers in series (30 stages
// for z/z0 and 32 stages for the radial and constant-Br quotients) plus the
// multiply stages of the blend, and takes one beat every clock unless the
// output stalls. A stall on the output freezes the whole pipeline, so no beat
// is lost or repeated. The user must write configuration registers only while
// the pipeline is empty; the block does not enforce this and reads them live.
module axisymmetric_mag_field_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  axial_pos_i,
  input  logic [30:0]         radius_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  axial_field_o,
  output logic signed [31:0]  radial_field_o,
  output logic signed [31:0]  vector_potential_o,
  output logic [1:0]          status_o
);
  import afe_pkg::*;

  typedef struct packed {
    cr_t  cr;
    logic dvd;
    logic to_bz;
    logic ovf;
    logic divz;
  } d2_t;

  // Configuration registers.
  kind_e              field_kind_q;
  logic signed [31:0] base_field_q, high_field_q, gradient_q;
  logic [30:0]        half_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_kind_q  <= KIND_CONST_BZ;
      base_field_q  <= '0;
      high_field_q  <= '0;
      gradient_q    <= '0;
      half_length_q <= 31'd1 << FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIELD_KIND:  field_kind_q  <= kind_e'(cfg_data_i[1:0]);
        REG_BASE_FIELD:  base_field_q  <= cfg_data_i;
        REG_HIGH_FIELD:  high_field_q  <= cfg_data_i;
        REG_GRADIENT:    gradient_q    <= cfg_data_i;
        REG_HALF_LENGTH: half_length_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished beat is held at the output.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: the products of the linear and constant-Br kinds.
  logic               s1_vld_q;
  logic signed [31:0] s1_z_q;
  logic [30:0]        s1_r_q;
  logic signed [63:0] s1_pk_q, s1_pkr_q, s1_pbz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_z_q   <= axial_pos_i;
      s1_r_q   <= radius_i;
      s1_pk_q  <= gradient_q * axial_pos_i;
      s1_pkr_q <= gradient_q * $signed({1'b0, radius_i});
      s1_pbz_q <= base_field_q * axial_pos_i;
    end
  end

  // Stage 2: saturate the simple kinds and classify the bi-uniform position.
  sat_t               lin_bz_s, lin_br_s, br_at_s;
  logic signed [63:0] num;
  logic [31:0]        az;
  logic signed [32:0] z_ext, z0_ext;
  cr_t                s2_cr_d, s2_cr_q;
  logic [30:0]        s2_rem_q;
  logic               s2_vld_q;

  assign lin_bz_s = sat32(64'(base_field_q) + (s1_pk_q >>> FRAC_BITS));
  assign lin_br_s = sat32((-s1_pkr_q) >>> (FRAC_BITS + 1));
  assign num      = -s1_pbz_q;
  assign br_at_s  = sat32(num >>> FRAC_BITS);
  assign az       = s1_z_q[31] ? 32'(-s1_z_q) : 32'(s1_z_q);
  assign z_ext    = 33'(s1_z_q);
  assign z0_ext   = $signed({2'b00, half_length_q});

  always_comb begin
    s2_cr_d         = '0;
    s2_cr_d.r       = s1_r_q;
    s2_cr_d.z_neg   = s1_z_q[31];
    s2_cr_d.bz      = base_field_q;
    case (field_kind_q)
      KIND_LINEAR_BZ: begin
        s2_cr_d.bz  = lin_bz_s.v;
        s2_cr_d.br  = lin_br_s.v;
        s2_cr_d.sat = lin_bz_s.ov | lin_br_s.ov;
      end
      KIND_BIUNIFORM: begin
        if (half_length_q == '0) begin
          s2_cr_d.bz = (s1_z_q <= 0) ? base_field_q : high_field_q;
        end else if (z_ext <= -z0_ext) begin
          s2_cr_d.bz = base_field_q;
        end else if (z_ext >= z0_ext) begin
          s2_cr_d.bz = high_field_q;
        end else begin
          s2_cr_d.blend = 1'b1;
        end
      end
      KIND_CONST_BR: begin
        s2_cr_d.br      = base_field_q;
        s2_cr_d.at      = br_at_s.v;
        s2_cr_d.sat     = br_at_s.ov;
        s2_cr_d.res_neg = num[63];
        s2_cr_d.num_mag = 63'(num[63] ? -num : num);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cr_q  <= s2_cr_d;
      s2_rem_q <= s2_cr_d.blend ? az[30:0] : '0;
    end
  end

  // |z| / z0 as a fraction with UBITS bits; |z| is below z0 in the blend.
  logic                 d1_vld;
  logic [UBITS-1:0]     d1_quo;
  logic [$bits(cr_t)-1:0] d1_pay;

  afe_div #(
    .NB(UBITS),
    .DW(31),
    .PW($bits(cr_t))
  ) u_div_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .rem_i   (s2_rem_q),
    .low_i   ('0),
    .den_i   (half_length_q),
    .pay_i   (s2_cr_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .pay_o   (d1_pay)
  );

  logic               bl_vld;
  cr_t                bl_cr;
  logic [61:0]        bl_mr;
  logic signed [63:0] bl_ar;

  afe_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_vld),
    .quo_i   (d1_quo),
    .cr_i    (cr_t'(d1_pay)),
    .base_i  (base_field_q),
    .high_i  (high_field_q),
    .valid_o (bl_vld),
    .cr_o    (bl_cr),
    .mr_o    (bl_mr),
    .ar_o    (bl_ar)
  );

  // Stage 8: the vector potential, and the setup of the shared divider. The
  // quotient fits in 32 bits exactly when the upper numerator half is below
  // the divisor; otherwise the result saturates without dividing.
  sat_t        at_s;
  d2_t         s8_d;
  logic [30:0] hi, den;
  logic [31:0] lo;
  logic        is_br;

  assign is_br = (field_kind_q == KIND_CONST_BR);
  assign at_s  = sat32(bl_ar >>> (FRAC_BITS + 1));

  always_comb begin
    s8_d       = '0;
    s8_d.cr    = bl_cr;
    hi         = '0;
    lo         = '0;
    den        = half_length_q;
    if (is_br) begin
      hi         = bl_cr.num_mag[62:32];
      lo         = bl_cr.num_mag[31:0];
      den        = bl_cr.r;
      s8_d.dvd   = 1'b1;
      s8_d.to_bz = 1'b1;
      s8_d.divz  = (bl_cr.r == '0);
    end else begin
      s8_d.cr.at  = at_s.v;
      s8_d.cr.sat = bl_cr.sat | at_s.ov;
      if (bl_cr.blend) begin
        hi       = {1'b0, bl_mr[61:32]};
        lo       = bl_mr[31:0];
        s8_d.dvd = 1'b1;
      end
    end
    s8_d.ovf = (hi >= den);
  end

  logic        s8_vld_q;
  d2_t         s8_q;
  logic [30:0] s8_rem_q, s8_den_q;
  logic [31:0] s8_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= bl_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q     <= s8_d;
      s8_rem_q <= (s8_d.dvd && !s8_d.ovf) ? hi : '0;
      s8_low_q <= lo;
      s8_den_q <= den;
    end
  end

  logic                   d2_vld;
  logic [31:0]            d2_quo;
  logic [$bits(d2_t)-1:0] d2_pay;

  afe_div #(
    .NB(32),
    .DW(31),
    .PW($bits(d2_t))
  ) u_div_quo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_vld_q),
    .rem_i   (s8_rem_q),
    .low_i   (s8_low_q),
    .den_i   (s8_den_q),
    .pay_i   (s8_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .pay_o   (d2_pay)
  );

  // Final stage: sign and saturate the quotient and form the status.
  d2_t                f;
  logic signed [63:0] qs;
  sat_t               q_s;
  logic signed [31:0] qv;
  logic               fsat;
  cr_t                fcr;
  logic [1:0]         st_d;

  assign f   = d2_t'(d2_pay);
  assign qs  = $signed({32'b0, d2_quo});
  assign q_s = sat32(f.cr.res_neg ? -qs : qs);

  always_comb begin
    fcr  = f.cr;
    qv   = q_s.v;
    fsat = q_s.ov;
    if (f.divz) begin
      qv   = '0;
      fsat = 1'b0;
    end else if (f.ovf) begin
      qv   = f.cr.res_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      fsat = 1'b1;
    end
    if (f.dvd) begin
      fcr.sat = f.cr.sat | fsat;
      if (f.to_bz) begin
        fcr.bz = qv;
      end else begin
        fcr.br = qv;
      end
    end
    if (f.divz) begin
      st_d = ST_DIVZ;
    end else if (fcr.sat) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      axial_field_o      <= fcr.bz;
      radial_field_o     <= fcr.br;
      vector_potential_o <= fcr.at;
      status_o           <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: tb/sv/axisymmetric_mag_field_eval_checker.sv
`timescale 1ns / 1ps

module axisymmetric_mag_field_eval_checker
  import afe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] axial_pos_i,
  input  logic [30:0]        radius_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] axial_field_i,
  input  logic signed [31:0] radial_field_i,
  input  logic signed [31:0] vector_potential_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0] bz;
    logic [31:0] br;
    logic [31:0] at;
    status_e     st;
  } field_t;

  kind_e              kind_q;
  logic signed [31:0] base_q, high_q, grad_q;
  logic [30:0]        z0_q;
  field_t             expected_fields[$];

  function automatic longint clamp32(longint x, inout bit ov);
    if (x > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic field_t eval_field(logic signed [31:0] z_in, logic [30:0] r_in);
    longint z, r, b1, b2, d, z0, bz, br, at, num, az, u, u2, u3, u5, p, w, w2, t, mag, q;
    bit     ov;
    field_t f;
    z  = z_in;
    r  = r_in;
    b1 = base_q;
    b2 = high_q;
    z0 = z0_q;
    ov = 1'b0;
    bz = 0;
    br = 0;
    at = 0;
    f.st = ST_OK;
    case (kind_q)
      KIND_CONST_BZ: begin
        bz = b1;
        at = clamp32((bz * r) >>> 17, ov);
      end
      KIND_LINEAR_BZ: begin
        bz = clamp32(b1 + ((longint'(grad_q) * z) >>> 16), ov);
        br = clamp32((-(longint'(grad_q) * r)) >>> 17, ov);
        at = clamp32((bz * r) >>> 17, ov);
      end
      KIND_BIUNIFORM: begin
        d = b2 - b1;
        if (z0 == 0) begin
          bz = (z <= 0) ? b1 : b2;
        end else if (z <= -z0) begin
          bz = b1;
        end else if (z >= z0) begin
          bz = b2;
        end else begin
          az = (z < 0) ? -z : z;
          u  = (az << 30) / z0;
          if (z < 0) u = -u;
          u2 = (u * u) >>> 30;
          u3 = (u2 * u) >>> 30;
          u5 = (u3 * u2) >>> 30;
          p  = (3 * u5 - 10 * u3 + 15 * u + (64'sd8 << 30)) >>> 4;
          if (p < 0) p = 0;
          if (p > (64'sd1 << 30)) p = 64'sd1 << 30;
          bz = clamp32(b1 + ((d * p) >>> 30), ov);
          w  = (64'sd1 << 30) - u2;
          if (w < 0) w = 0;
          w2 = (w * w) >>> 30;
          t  = (((d * w2) >>> 30) * 15) >>> 5;
          mag = (t < 0) ? -t : t;
          q  = (mag * r) / z0;
          br = clamp32((t < 0) ? q : -q, ov);
        end
        at = clamp32((bz * r) >>> 17, ov);
      end
      default: begin
        num = -(b1 * z);
        br  = b1;
        at  = clamp32(num >>> 16, ov);
        if (r == 0) begin
          bz   = 0;
          f.st = ST_DIVZ;
        end else begin
          bz = clamp32(num / r, ov);
        end
      end
    endcase
    if (f.st == ST_OK && ov) f.st = ST_SAT;
    f.bz = bz[31:0];
    f.br = br[31:0];
    f.at = at[31:0];
    return f;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
  end

  assign pending_o = expected_fields.size();

  always @(posedge clk_i or negedge rst_ni) begin
    field_t want;
    if (!rst_ni) begin
      kind_q <= KIND_CONST_BZ;
      base_q <= '0;
      high_q <= '0;
      grad_q <= '0;
      z0_q   <= 31'h1_0000;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIELD_KIND:  kind_q <= kind_e'(cfg_data_i[1:0]);
          REG_BASE_FIELD:  base_q <= cfg_data_i;
          REG_HIGH_FIELD:  high_q <= cfg_data_i;
          REG_GRADIENT:    grad_q <= cfg_data_i;
          REG_HALF_LENGTH: z0_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_fields.push_back(eval_field(axial_pos_i, radius_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: result beat with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          want = expected_fields.pop_front();
          if (axial_field_i !== want.bz) report("axial_field", axial_field_i, want.bz);
          if (radial_field_i !== want.br) report("radial_field", radial_field_i, want.br);
          if (vector_potential_i !== want.at)
            report("vector_potential", vector_potential_i, want.at);
          if (status_i !== want.st) report("status", {30'd0, status_i}, {30'd0, want.st});
        end
      end
    end
  end

endmodule

FILE: tb/sv/axisymmetric_mag_field_eval_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the field evaluator. The checker beside the block
// predicts every result beat; this module only drives beats, configuration
// and stalls, and decides pass or fail at the end.
module axisymmetric_mag_field_eval_tb;
  import afe_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] axial_pos_i = '0;
  logic [30:0]        radius_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] axial_field_o, radial_field_o, vector_potential_o;
  logic [1:0]         status_o;
  int                 fail_count, pending;
  int                 cycles = 0;
  int                 beats_sent = 0;
  // While set, neither side idles: this gives a long back-to-back stretch.
  bit                 calm = 1'b0;

  always #6 clk_i = ~clk_i;

  axisymmetric_mag_field_eval i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .axial_pos_i, .radius_i,
    .out_valid_o, .out_stall_i, .axial_field_o, .radial_field_o,
    .vector_potential_o, .status_o
  );

  axisymmetric_mag_field_eval_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .axial_pos_i, .radius_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .axial_field_i(axial_field_o), .radial_field_i(radial_field_o),
    .vector_potential_i(vector_potential_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls about a third of the time, except in the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 32);
  end

  // Watchdog: far above the slowest legal run, which includes pauses for the
  // pipeline to drain between every configuration phase.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // A value whose magnitude spans all scales, with a random sign.
  function automatic logic [31:0] any_scale();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Registers change only with the pipeline empty, so first wait for every
  // expected result beat and then give the latency a little margin.
  task automatic configure(kind_e kind, logic [31:0] b1, logic [31:0] b2,
                           logic [31:0] k, logic [30:0] z0);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    set_reg(REG_FIELD_KIND, {30'd0, kind});
    set_reg(REG_BASE_FIELD, b1);
    set_reg(REG_HIGH_FIELD, b2);
    set_reg(REG_GRADIENT, k);
    set_reg(REG_HALF_LENGTH, {1'b0, z0});
    cfg_we_i <= 1'b0;
  endtask

  // Offers one beat, idling the sender at random first, and returns once the
  // block has accepted it. valid is only lowered when an idle gap is taken.
  task automatic send_beat(logic [31:0] z, logic [30:0] r);
    if (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    axial_pos_i <= z;
    radius_i    <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  // Edge points of the input space for the current configuration.
  task automatic send_corners(logic [30:0] z0);
    send_beat(32'h8000_0000, 31'h7FFF_FFFF);
    send_beat(32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_beat(32'h0, 31'h0);
    send_beat({1'b0, z0}, 31'h1_0000);
    send_beat(-{1'b0, z0}, 31'h1_0000);
    stop_sending();
  endtask

  initial begin
    int          kind_sel;
    logic [30:0] z0;
    logic [31:0] z;
    logic [30:0] r;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: constant Bz of zero.
    send_beat(32'h0001_0000, 31'h0002_0000);
    stop_sending();

    // Directed part: each kind, extreme registers, and the guarded divisions.
    configure(KIND_CONST_BZ, 32'h7FFF_FFFF, 32'h0, 32'h0, 31'h1_0000);
    send_corners(31'h1_0000);
    configure(KIND_LINEAR_BZ, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 31'h1_0000);
    send_corners(31'h1_0000);
    configure(KIND_BIUNIFORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h2_0000);
    send_corners(31'h2_0000);
    send_beat(32'h0000_8000, 31'h7FFF_FFFF);
    send_beat(32'hFFFF_0001, 31'h0003_0000);
    stop_sending();
    // Zero half-length turns the blend into a step at z = 0.
    configure(KIND_BIUNIFORM, 32'h0001_0000, 32'hFFFE_0000, 32'h0, 31'h0);
    send_beat(32'h0, 31'h1_0000);
    send_beat(32'h1, 31'h1_0000);
    send_beat(32'hFFFF_FFFF, 31'h1_0000);
    stop_sending();
    // Constant Br at zero radius reports a divide flag.
    configure(KIND_CONST_BR, 32'h8000_0000, 32'h0, 32'h8000_0000, 31'h7FFF_FFFF);
    send_corners(31'h7FFF_FFFF);
    send_beat(32'h8000_0000, 31'h1);
    stop_sending();

    // Random part: mostly ordinary scales, sometimes register extremes. The
    // third phase runs with no idling on either side.
    for (int phase = 0; phase < 12; phase++) begin
      kind_sel = phase % 4;
      z0 = $urandom_range(3) == 0 ? ($urandom_range(1) ? 31'h7FFF_FFFF : 31'h1)
                                  : 31'($urandom >> $urandom_range(1, 31));
      configure(kind_e'(kind_sel), any_scale(), any_scale(), any_scale(), z0);
      calm = (phase == 2);
      repeat (60) begin
        r = 31'($urandom >> $urandom_range(1, 31));
        if ($urandom_range(9) == 0) r = 31'($urandom_range(1) ? 0 : 31'h7FFF_FFFF);
        // For the blend, keep most positions within and around [-z0, z0].
        if (kind_sel == KIND_BIUNIFORM && $urandom_range(3) != 0)
          z = 32'($signed({1'b0, 32'($urandom_range(0, z0))})) * ($urandom_range(1) ? 1 : -1)
              + 32'($signed(32'($urandom_range(0, 8)) - 4));
        else
          z = any_scale();
        send_beat(z, r);
      end
      stop_sending();
      calm = 1'b0;
    end

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d beats over all four field kinds, including register extremes,",
             beats_sent);
    $display("step and divide guards, with random stalls on both channels.");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
